// ===== hw/rtl/stepper_ramp_position_controller_core_defines.svh =====
// Assertion macros shared by the stepper ramp controller RTL.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef STEPPER_RAMP_POSITION_CONTROLLER_CORE_DEFINES_SVH
`define STEPPER_RAMP_POSITION_CONTROLLER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside of reset.
`define SRPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition never holds outside of reset.
`define SRPC_ASSERT_NEVER(lbl, cond, msg) \
  `SRPC_ASSERT(lbl, !(cond), msg)
`else
`define SRPC_ASSERT(lbl, prop, msg)
`define SRPC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hw/rtl/srpc_pkg.sv =====
// Package of the stepper ramp position controller: widths, codes and types.
// No dependencies; the interfaces, the core and the divider refer to it by scoped names.
`timescale 1ns / 1ps

package srpc_pkg;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PERIOD_W   = 32;
  localparam int unsigned PRESS_W    = 8;

  // Register reset values.
  localparam int unsigned FREQ_LO_RST     = 100;
  localparam int unsigned FREQ_HI_RST     = 1000;
  localparam int unsigned MAX_POS_RST     = 10000;
  localparam int unsigned MAX_PRESSES_RST = 10;
  localparam int unsigned TIMER_CLK_RST   = 1000000;

  localparam logic [PRESS_W-1:0] PRESS_SAT = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_RAMP  = 3'd0,
    KIND_STEP  = 3'd1,
    KIND_UP    = 3'd2,
    KIND_DOWN  = 3'd3,
    KIND_STOP  = 3'd4,
    KIND_ESTOP = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ_LO     = 3'd0,
    CFG_FREQ_HI     = 3'd1,
    CFG_MAX_POS     = 3'd2,
    CFG_ACCEL_EN    = 3'd3,
    CFG_MAX_PRESSES = 3'd4,
    CFG_TIMER_CLK   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hw/rtl/srpc_if.sv =====
// Valid/ready channel interfaces of the stepper ramp position controller.
// Depends on srpc_pkg for field widths.
`timescale 1ns / 1ps

interface srpc_in_if;
  logic                             valid;
  logic                             ready;
  logic [srpc_pkg::KIND_W-1:0]      kind;
  logic                             limit_up;
  logic                             limit_down;
  logic                             stop_button;

  modport source (output valid, kind, limit_up, limit_down, stop_button, input ready);
  modport sink   (input valid, kind, limit_up, limit_down, stop_button, output ready);
endinterface

interface srpc_out_if #(
  parameter int unsigned FREQ_BITS = 16,
  parameter int unsigned POS_BITS  = 16
);
  logic                          valid;
  logic                          ready;
  logic                          step_level;
  logic                          direction;
  logic                          driver_enable;
  logic                          running;
  logic                          decelerating;
  logic                          halted;
  logic [FREQ_BITS-1:0]          frequency;
  logic [srpc_pkg::PERIOD_W-1:0] step_period;
  logic [POS_BITS-1:0]           position;
  logic                          init_request;

  modport source (output valid, step_level, direction, driver_enable, running,
                  decelerating, halted, frequency, step_period, position,
                  init_request, input ready);
  modport sink   (input valid, step_level, direction, driver_enable, running,
                  decelerating, halted, frequency, step_period, position,
                  init_request, output ready);
endinterface

interface srpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [srpc_pkg::CFG_IDX_W-1:0]  index;
  logic [srpc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/stepper_ramp_position_controller_core.sv =====
// Top level of the stepper ramp position controller.
// Depends on srpc_pkg, the channel interfaces in srpc_if and the divider srpc_div.
`timescale 1ns / 1ps
`include "stepper_ramp_position_controller_core_defines.svh"

// The block takes one motor event per item (ramp tick, step tick, start up,
// start down, stop request, emergency stop) with the sampled limit switch and
// stop button levels, and returns one result item with the full controller
// state after that event. Events that need no step period present their result
// right after the accepting edge. A ramp tick while the ramp runs, and a stop
// that completes while the step generator runs with acceleration enabled,
// compute the period timer_clock / frequency (the lower frequency for a stop)
// in a serial restoring divider that yields one quotient bit per cycle, and
// no new item is taken while it divides. The input is ready again once the
// result is taken, or in the same cycle as it is taken. Configuration writes
// are accepted in every cycle and must only be issued while the block is idle.
// Direction 1 moves the position toward zero and is guarded by the lower limit
// switch; direction 0 moves it toward max_position and is guarded by the upper
// limit switch.
module stepper_ramp_position_controller_core #(
  parameter int unsigned FREQ_BITS = 16,
  parameter int unsigned POS_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  srpc_in_if.sink     in_i,
  srpc_out_if.source  out_o,
  srpc_cfg_if.sink    cfg_i
);

  // Configuration registers.
  logic [FREQ_BITS-1:0]          freq_lo_q;
  logic [FREQ_BITS-1:0]          freq_hi_q;
  logic [POS_BITS-1:0]           max_pos_q;
  logic                          accel_en_q;
  logic [srpc_pkg::PRESS_W-1:0]  max_presses_q;
  logic [srpc_pkg::PERIOD_W-1:0] timer_clk_q;

  // Controller state; the result item is read straight from these registers.
  logic                          step_line_q, step_line_d;
  logic                          dir_up_q, dir_up_d;
  logic                          drv_en_q, drv_en_d;
  logic                          step_run_q, step_run_d;
  logic                          ramp_run_q, ramp_run_d;
  logic                          stopping_q, stopping_d;
  logic                          stopped_q, stopped_d;
  logic                          start_up_q, start_up_d;
  logic                          start_dn_q, start_dn_d;
  logic [FREQ_BITS-1:0]          freq_q, freq_d;
  logic [srpc_pkg::PERIOD_W-1:0] period_q, period_d;
  logic [POS_BITS-1:0]           pos_q, pos_d;
  logic [srpc_pkg::PRESS_W-1:0]  press_q, press_d;
  logic                          init_q, init_d;

  // Sequencer.
  srpc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  logic                          in_fire;
  logic                          out_fire;
  logic                          need_div;
  logic [FREQ_BITS-1:0]          div_divisor;
  logic [srpc_pkg::PERIOD_W-1:0] div_quotient;
  srpc_pkg::div_status_t         div_st;
  srpc_pkg::kind_e               kind;
  logic                          move_up;
  logic                          move_blocked;

  assign kind         = srpc_pkg::kind_e'(in_i.kind);
  assign in_fire      = in_i.valid && in_i.ready;
  assign out_fire     = out_o.valid && out_o.ready;
  assign move_up      = (kind == srpc_pkg::KIND_UP);
  assign move_blocked = move_up ? in_i.limit_down : in_i.limit_up;

  // Configuration port.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_lo_q     <= FREQ_BITS'(srpc_pkg::FREQ_LO_RST);
      freq_hi_q     <= FREQ_BITS'(srpc_pkg::FREQ_HI_RST);
      max_pos_q     <= POS_BITS'(srpc_pkg::MAX_POS_RST);
      accel_en_q    <= 1'b1;
      max_presses_q <= srpc_pkg::PRESS_W'(srpc_pkg::MAX_PRESSES_RST);
      timer_clk_q   <= srpc_pkg::PERIOD_W'(srpc_pkg::TIMER_CLK_RST);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (srpc_pkg::cfg_idx_e'(cfg_i.index))
        srpc_pkg::CFG_FREQ_LO:     freq_lo_q     <= cfg_i.data[FREQ_BITS-1:0];
        srpc_pkg::CFG_FREQ_HI:     freq_hi_q     <= cfg_i.data[FREQ_BITS-1:0];
        srpc_pkg::CFG_MAX_POS:     max_pos_q     <= cfg_i.data[POS_BITS-1:0];
        srpc_pkg::CFG_ACCEL_EN:    accel_en_q    <= cfg_i.data[0];
        srpc_pkg::CFG_MAX_PRESSES: max_presses_q <= cfg_i.data[srpc_pkg::PRESS_W-1:0];
        srpc_pkg::CFG_TIMER_CLK:   timer_clk_q   <= cfg_i.data[srpc_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Event handling. Everything but the step period settles at acceptance; the
  // period is taken from the divider when it reports done.
  always_comb begin
    step_line_d = step_line_q;
    dir_up_d    = dir_up_q;
    drv_en_d    = drv_en_q;
    step_run_d  = step_run_q;
    ramp_run_d  = ramp_run_q;
    stopping_d  = stopping_q;
    stopped_d   = stopped_q;
    start_up_d  = start_up_q;
    start_dn_d  = start_dn_q;
    freq_d      = freq_q;
    period_d    = period_q;
    pos_d       = pos_q;
    press_d     = press_q;
    init_d      = init_q;
    need_div    = 1'b0;
    div_divisor = freq_q;

    if (in_fire) begin
      case (kind)
        srpc_pkg::KIND_RAMP: begin
          // The period is latched from the frequency before this tick moves it.
          if (ramp_run_q) begin
            need_div    = 1'b1;
            div_divisor = freq_q;
            if (freq_q > freq_lo_q && stopping_q) begin
              freq_d = freq_q - FREQ_BITS'(1);
            end else if (freq_q < freq_hi_q && (start_up_q || start_dn_q)) begin
              freq_d = freq_q + FREQ_BITS'(1);
            end
          end
        end
        srpc_pkg::KIND_STEP: begin
          if (step_run_q) begin
            if (dir_up_q) begin
              if (!in_i.limit_down && !in_i.stop_button) begin
                step_line_d = !step_line_q;
                if (pos_q != '0) begin
                  pos_d = pos_q - POS_BITS'(1);
                end
              end else begin
                pos_d   = '0;
                press_d = '0;
              end
            end else begin
              if (!in_i.limit_up && !in_i.stop_button) begin
                step_line_d = !step_line_q;
                if (pos_q < max_pos_q) begin
                  pos_d = pos_q + POS_BITS'(1);
                end
              end else begin
                pos_d   = max_pos_q;
                press_d = '0;
              end
            end
          end
        end
        srpc_pkg::KIND_UP, srpc_pkg::KIND_DOWN: begin
          if (move_up) begin
            start_up_d = 1'b1;
          end else begin
            start_dn_d = 1'b1;
          end
          if (!stopping_q && !move_blocked && !step_run_q) begin
            drv_en_d   = 1'b1;
            stopped_d  = 1'b0;
            dir_up_d   = move_up;
            ramp_run_d = 1'b1;
            step_run_d = 1'b1;
            if (accel_en_q) begin
              freq_d = freq_lo_q;
            end
            if (press_q != srpc_pkg::PRESS_SAT) begin
              press_d = press_q + srpc_pkg::PRESS_W'(1);
            end
          end else if (freq_q == freq_lo_q && stopping_q) begin
            // A start during the last stage of a stop reverses and resumes.
            dir_up_d   = move_up;
            stopping_d = 1'b0;
          end
        end
        srpc_pkg::KIND_STOP: begin
          if (!stopped_q) begin
            stopping_d = 1'b1;
            if (freq_q <= freq_lo_q) begin
              stopped_d  = 1'b1;
              start_up_d = 1'b0;
              start_dn_d = 1'b0;
              drv_en_d   = 1'b0;
              ramp_run_d = 1'b0;
              stopping_d = 1'b0;
              if (step_run_q) begin
                step_run_d = 1'b0;
                if (accel_en_q) begin
                  need_div    = 1'b1;
                  div_divisor = freq_lo_q;
                end
              end
              if (press_q >= max_presses_q) begin
                init_d = 1'b1;
              end
            end
          end
        end
        srpc_pkg::KIND_ESTOP: begin
          // The driver enable is deliberately left as it was.
          start_up_d = 1'b0;
          start_dn_d = 1'b0;
          stopped_d  = 1'b1;
          ramp_run_d = 1'b0;
          step_run_d = 1'b0;
          stopping_d = 1'b0;
          freq_d     = freq_lo_q;
        end
        default: ;
      endcase
    end

    if (div_st.done) begin
      period_d = div_quotient;
    end
  end

  srpc_div #(
    .FREQ_BITS (FREQ_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (need_div),
    .dividend_i (timer_clk_q),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient),
    .status_o   (div_st)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srpc_pkg::ST_IDLE: begin
        if (in_fire && need_div) begin
          state_d = srpc_pkg::ST_DIV;
        end
      end
      srpc_pkg::ST_DIV: begin
        if (div_st.done) begin
          state_d = srpc_pkg::ST_IDLE;
        end
      end
      default: state_d = srpc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs. A new item may enter in the cycle its predecessor's
  // result is taken, since that result is read from the state registers.
  always_comb begin
    in_i.ready  = 1'b0;
    out_valid_d = out_valid_q;
    case (state_q)
      srpc_pkg::ST_IDLE: begin
        in_i.ready = !out_valid_q || out_o.ready;
        if (in_fire && !need_div) begin
          out_valid_d = 1'b1;
        end else if (out_fire) begin
          out_valid_d = 1'b0;
        end
      end
      srpc_pkg::ST_DIV: begin
        if (div_st.done) begin
          out_valid_d = 1'b1;
        end
      end
      default: out_valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srpc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      step_line_q <= 1'b0;
      dir_up_q    <= 1'b0;
      drv_en_q    <= 1'b0;
      step_run_q  <= 1'b0;
      ramp_run_q  <= 1'b0;
      stopping_q  <= 1'b0;
      stopped_q   <= 1'b1;
      start_up_q  <= 1'b0;
      start_dn_q  <= 1'b0;
      freq_q      <= FREQ_BITS'(srpc_pkg::FREQ_LO_RST);
      period_q    <= '0;
      pos_q       <= '0;
      press_q     <= '0;
      init_q      <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_line_q <= step_line_d;
      dir_up_q    <= dir_up_d;
      drv_en_q    <= drv_en_d;
      step_run_q  <= step_run_d;
      ramp_run_q  <= ramp_run_d;
      stopping_q  <= stopping_d;
      stopped_q   <= stopped_d;
      start_up_q  <= start_up_d;
      start_dn_q  <= start_dn_d;
      freq_q      <= freq_d;
      period_q    <= period_d;
      pos_q       <= pos_d;
      press_q     <= press_d;
      init_q      <= init_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.step_level    = step_line_q;
  assign out_o.direction     = dir_up_q;
  assign out_o.driver_enable = drv_en_q;
  assign out_o.running       = step_run_q;
  assign out_o.decelerating  = stopping_q;
  assign out_o.halted        = stopped_q;
  assign out_o.frequency     = freq_q;
  assign out_o.step_period   = period_q;
  assign out_o.position      = pos_q;
  assign out_o.init_request  = init_q;

  // A running generator and a pending stop both imply the motor is not halted.
  `SRPC_ASSERT(a_run_not_halted, step_run_q |-> !stopped_q, "running while halted")
  `SRPC_ASSERT(a_stop_not_halted, stopping_q |-> !stopped_q, "decelerating while halted")
  `SRPC_ASSERT_NEVER(a_no_accept_busy, in_i.ready && div_st.busy, "item taken during divide")
  `SRPC_ASSERT(a_done_publishes, div_st.done |=> out_valid_q, "divide result not published")
  `SRPC_ASSERT_NEVER(a_no_valid_busy, out_valid_q && div_st.busy, "result shown during divide")

endmodule

// ===== hw/rtl/srpc_div.sv =====
// Serial restoring divider: one quotient bit per cycle for the step period.
// Depends on srpc_pkg for the dividend width and the status struct.
`timescale 1ns / 1ps

module srpc_div #(
  parameter int unsigned FREQ_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [srpc_pkg::PERIOD_W-1:0] dividend_i,
  input  logic [FREQ_BITS-1:0]          divisor_i,
  output logic [srpc_pkg::PERIOD_W-1:0] quotient_o,
  output srpc_pkg::div_status_t         status_o
);

  localparam int unsigned CNT_W = $clog2(srpc_pkg::PERIOD_W);

  logic [srpc_pkg::PERIOD_W-1:0] quo_q, quo_d;
  logic [FREQ_BITS-1:0]          rem_q, rem_d;
  logic [FREQ_BITS-1:0]          dsr_q, dsr_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;

  logic [FREQ_BITS:0] rem_shift;
  logic [FREQ_BITS:0] diff;

  // A zero divisor never borrows, so the quotient comes out all ones.
  assign rem_shift = {rem_q, quo_q[srpc_pkg::PERIOD_W-1]};
  assign diff      = rem_shift - {1'b0, dsr_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CNT_W'(srpc_pkg::PERIOD_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_shift >= {1'b0, dsr_q}) begin
        rem_d = diff[FREQ_BITS-1:0];
        quo_d = {quo_q[srpc_pkg::PERIOD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[FREQ_BITS-1:0];
        quo_d = {quo_q[srpc_pkg::PERIOD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule
